// File: sv/hvne_pkg.sv
// ----------------------------------------------------------------------------
// hvne_pkg: shared types and constants for the heightmap vertex engine
// Payload structs, register indexes and grid limits.
// ----------------------------------------------------------------------------
package hvne_pkg;

  localparam int unsigned MaxColumns = 256;
  localparam int unsigned MaxRows    = 256;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned RowW       = $clog2(MaxRows);
  localparam int unsigned AddrW      = ColW + RowW;

  localparam logic [1:0] RegColumns = 2'd0;
  localparam logic [1:0] RegRows    = 2'd1;
  localparam logic [1:0] RegSpacing = 2'd2;
  localparam logic [1:0] RegScale   = 2'd3;

  localparam logic OpStore = 1'b0;
  localparam logic OpRead  = 1'b1;

  // (1,1,0)/sqrt(2) in Q30
  localparam logic [29:0] InvSqrt2Q30 = 30'd759250125;

  typedef struct packed {
    logic        op;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] height;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic [23:0]        pos_y;
    logic signed [23:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] shade;
  } out_item_t;

  typedef struct packed {
    logic [2:0] reg_idx;
    logic [31:0] data;
  } cfg_item_t;

endpackage

// File: sv/heightmap_vertex_normal_engine.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_engine: heightmap store and vertex attribute engine
// Stores Q8.8 heights and answers vertex reads with position, texture
// coordinate, averaged unit normal and shade.
// ----------------------------------------------------------------------------
// A store item is taken while the block is idle and leaves it idle, so stores
// can follow back to back. A read item runs a sequencer that fetches heights
// one at a time from the single-port height memory and pushes up to six
// triangle normalizations, the final normalization and the two texture
// divisions through one shared 64-step bit-serial divider and one shared
// multiplier. Each normalization shifts its components into range, then uses
// a bit-serial square root of 32 steps and three divisions. A finished result
// waits in an output register; the next read stalls at its end only while
// that register is still held by the receiver. Items outside the grid give no
// result.
module heightmap_vertex_normal_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hvne_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hvne_pkg::out_item_t   out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  hvne_pkg::cfg_item_t   cfg_data_i
);
  import hvne_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_POS, S_FACE_SEL, S_FETCH, S_FETCH_W, S_FACE_MUL, S_NORM_ABS,
    S_NORM_SHIFT, S_NORM_SQ, S_SQRT, S_NORM_DIV, S_NORM_DIV_W, S_NORM_DONE,
    S_TEX_DIV, S_TEX_DIV_W, S_SHADE, S_OUT
  } state_e;

  state_e state_q;

  logic [8:0]  cols_q, rows_q;
  logic [15:0] spacing_q, scale_q;
  logic [15:0] mem [MaxRows*MaxColumns];
  logic [15:0] rdata_q;

  in_item_t    item_q;
  out_item_t   res_q;
  out_item_t   out_q;
  logic        out_valid_q;

  // effective dimensions
  logic [8:0] ecols, erows, lc, lr;
  always_comb begin
    ecols = (cols_q < 9'd2) ? 9'd2 : ((cols_q > 9'(MaxColumns)) ? 9'(MaxColumns) : cols_q);
    erows = (rows_q < 9'd2) ? 9'd2 : ((rows_q > 9'(MaxRows)) ? 9'(MaxRows) : rows_q);
    lc = ecols - 9'd1;
    lr = erows - 9'd1;
  end

  // face bookkeeping
  logic [2:0] face_q;          // 0..5 face slot, 6 once all are done
  logic [1:0] hidx_q;          // which height of the face
  logic [15:0] ha_q, hb_q, hc_q;
  logic [7:0] fr_q, fc_q;
  logic       fsec_q;
  logic signed [63:0] acc_q [3];
  logic signed [63:0] vec_q [3];
  logic [63:0] mag_q [3];
  logic [5:0]  norm_q;         // output scale q
  logic        final_q;
  logic [63:0] sum_q;
  logic [63:0] sq_rem_q, sq_res_q, sq_bit_q;
  logic [1:0]  comp_q;
  logic [6:0]  shcnt_q;
  logic        tex_q;
  logic [15:0] hcen_q;

  // face slot validity and cell
  logic        fvalid;
  logic [7:0]  cell_r, cell_c;
  logic        cell_sec;
  always_comb begin
    fvalid = 1'b0; cell_r = item_q.row; cell_c = item_q.col; cell_sec = 1'b0;
    unique case (face_q)
      3'd0: begin fvalid = ({1'b0,item_q.row} < lr) && ({1'b0,item_q.col} < lc); end
      3'd1: begin fvalid = ({1'b0,item_q.row} < lr) && (item_q.col != 8'd0);
                  cell_c = item_q.col - 8'd1; end
      3'd2: begin fvalid = ({1'b0,item_q.row} < lr) && (item_q.col != 8'd0);
                  cell_c = item_q.col - 8'd1; cell_sec = 1'b1; end
      3'd3: begin fvalid = (item_q.row != 8'd0) && ({1'b0,item_q.col} < lc);
                  cell_r = item_q.row - 8'd1; end
      3'd4: begin fvalid = (item_q.row != 8'd0) && ({1'b0,item_q.col} < lc);
                  cell_r = item_q.row - 8'd1; cell_sec = 1'b1; end
      3'd5: begin fvalid = (item_q.row != 8'd0) && (item_q.col != 8'd0);
                  cell_r = item_q.row - 8'd1; cell_c = item_q.col - 8'd1;
                  cell_sec = 1'b1; end
      default: fvalid = 1'b0;
    endcase
  end

  // height address of the current fetch: A uses (r,c),(r,c+1),(r+1,c);
  // B uses (r+1,c+1),(r+1,c),(r,c+1)
  logic [7:0] har, hac;
  always_comb begin
    har = fr_q; hac = fc_q;
    if (!fsec_q) begin
      unique case (hidx_q)
        2'd1: hac = fc_q + 8'd1;
        2'd2: har = fr_q + 8'd1;
        default: ;
      endcase
    end else begin
      unique case (hidx_q)
        2'd0: begin har = fr_q + 8'd1; hac = fc_q + 8'd1; end
        2'd1: har = fr_q + 8'd1;
        2'd2: hac = fc_q + 8'd1;
        default: ;
      endcase
    end
  end

  logic        mem_we;
  logic [AddrW-1:0] mem_addr;
  always_comb begin
    mem_we   = (state_q == S_IDLE) && in_valid_i && (in_data_i.op == OpStore)
               && ({1'b0,in_data_i.row} < erows) && ({1'b0,in_data_i.col} < ecols);
    mem_addr = (state_q == S_IDLE) ? {in_data_i.row, in_data_i.col}
             : (state_q == S_POS) ? {item_q.row, item_q.col} : {har, hac};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= in_data_i.height;
    rdata_q <= mem[mem_addr];
  end

  // shared multiplier: 33 x 33 signed
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // shared divider
  logic        div_start, div_busy;
  logic [63:0] div_num, div_quot;
  logic [31:0] div_den;
  hvne_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(div_quot)
  );

  // combinational helpers
  logic [63:0] mx;
  logic [63:0] sq_trial;
  always_comb begin
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
    sq_trial = sq_res_q + sq_bit_q;
  end

  logic signed [63:0] shade_sum, shade_mag;
  logic [63:0]        shade_abs;
  logic [39:0]        posy_val;
  always_comb begin
    shade_sum = vec_q[0] + vec_q[1];
    shade_abs = shade_sum[63] ? 64'(-shade_sum) : 64'(shade_sum);
    shade_mag = 64'((mul_p + 66'sd536870912) >>> 30);
    posy_val  = 40'((mul_p[47:0] + 48'd128) >> 8);
  end

  always_comb begin
    mul_a = '0; mul_b = '0; div_start = 1'b0; div_num = '0; div_den = '0;
    unique case (state_q)
      S_POS: begin
        mul_a = 33'(signed'({1'b0, item_q.col, 1'b0}) - signed'({1'b0, lc}));
        mul_b = signed'({17'd0, spacing_q});
      end
      S_FACE_MUL: begin
        mul_a = 33'(signed'({1'b0, ha_q}) - signed'({1'b0, hb_q}));
        mul_b = signed'({17'd0, scale_q});
      end
      S_NORM_SQ: begin
        mul_a = signed'({1'b0, mag_q[comp_q][31:0]});
        mul_b = signed'({1'b0, mag_q[comp_q][31:0]});
      end
      S_SHADE: begin
        mul_a = signed'({1'b0, sum_q[31:0]});
        mul_b = signed'({3'd0, InvSqrt2Q30});
      end
      S_NORM_DIV: begin
        div_start = 1'b1;
        div_num = (mag_q[comp_q] << norm_q) + (sq_res_q >> 1);
        div_den = sq_res_q[31:0];
      end
      S_TEX_DIV: begin
        div_start = 1'b1;
        if (!tex_q) begin
          // height times scale for pos_y
          mul_a = signed'({17'd0, hcen_q});
          mul_b = signed'({17'd0, scale_q});
          div_num = {39'd0, item_q.col, 17'd0} + {55'd0, lc};
          div_den = {22'd0, lc, 1'b0};
        end else begin
          // negated row offset for pos_z
          mul_a = 33'(signed'({1'b0, lr}) - signed'({1'b0, item_q.row, 1'b0}));
          mul_b = signed'({17'd0, spacing_q});
          div_num = {39'd0, item_q.row, 17'd0} + {55'd0, lr};
          div_den = {22'd0, lr, 1'b0};
        end
      end
      default: ;
    endcase
  end

  function automatic logic signed [23:0] half_sat(input logic signed [65:0] p);
    logic [65:0] m;
    logic [65:0] r;
    logic signed [66:0] s;
    begin
      m = p[65] ? 66'(-p) : 66'(p);
      r = (m + 66'd1) >> 1;
      s = p[65] ? -signed'({1'b0, r}) : signed'({1'b0, r});
      if (s > 67'sd8388607) half_sat = 24'sd8388607;
      else if (s < -67'sd8388608) half_sat = -24'sd8388608;
      else half_sat = s[23:0];
    end
  endfunction

  function automatic logic signed [15:0] sat14(input logic signed [63:0] v);
    begin
      if (v > 64'sd16384) sat14 = 16'sd16384;
      else if (v < -64'sd16384) sat14 = -16'sd16384;
      else sat14 = v[15:0];
    end
  endfunction

  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      cols_q <= 9'd2; rows_q <= 9'd2;
      spacing_q <= 16'd256; scale_q <= 16'd256;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q <= res_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_data_i.reg_idx)
          {1'b0, RegColumns}: cols_q <= cfg_data_i.data[8:0];
          {1'b0, RegRows}:    rows_q <= cfg_data_i.data[8:0];
          {1'b0, RegSpacing}: spacing_q <= cfg_data_i.data[15:0];
          {1'b0, RegScale}:   scale_q <= cfg_data_i.data[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          item_q <= in_data_i;
          if (in_data_i.op == OpRead && ({1'b0,in_data_i.row} < erows)
              && ({1'b0,in_data_i.col} < ecols)) state_q <= S_POS;
        end
        S_POS: begin
          res_q.pos_x <= half_sat(mul_p);
          for (int i = 0; i < 3; i++) acc_q[i] <= '0;
          face_q <= '0;
          state_q <= S_FETCH_W;  // rdata holds the centre height next
          hidx_q <= 2'd3;
        end
        S_FETCH_W: begin
          if (hidx_q == 2'd3) begin
            hcen_q <= rdata_q;
            state_q <= S_FACE_SEL;
          end else begin
            unique case (hidx_q)
              2'd0: ha_q <= rdata_q;
              2'd1: hb_q <= rdata_q;
              default: hc_q <= rdata_q;
            endcase
            if (hidx_q == 2'd2) begin
              state_q <= S_FACE_MUL; comp_q <= 2'd0;
            end else begin
              hidx_q <= hidx_q + 2'd1; state_q <= S_FETCH;
            end
          end
        end
        S_FACE_SEL: begin
          if (face_q == 3'd6) begin
            vec_q <= acc_q; norm_q <= 6'd14; final_q <= 1'b1;
            state_q <= S_NORM_ABS;
          end else if (fvalid && spacing_q != 16'd0) begin
            fr_q <= cell_r; fc_q <= cell_c; fsec_q <= cell_sec;
            hidx_q <= 2'd0; state_q <= S_FETCH;
          end else begin
            face_q <= face_q + 3'd1;
          end
        end
        S_FETCH: state_q <= S_FETCH_W;
        S_FACE_MUL: begin
          // A: x = -(h01-h00)k, z = (h10-h00)k ; ha=h00 hb=h01 hc=h10
          // B: x = -(h11-h10)k, z = (h11-h01)k ; ha=h11 hb=h10 hc=h01
          if (comp_q == 2'd0) begin
            if (!fsec_q) vec_q[0] <= 64'(mul_p);
            else vec_q[0] <= -64'(mul_p);
            hb_q <= hc_q; comp_q <= 2'd1;
          end else begin
            if (!fsec_q) vec_q[2] <= -64'(mul_p);
            else vec_q[2] <= 64'(mul_p);
            vec_q[1] <= 64'({spacing_q, 8'd0});
            norm_q <= 6'd28; final_q <= 1'b0;
            state_q <= S_NORM_ABS;
          end
        end
        S_NORM_ABS: begin
          for (int i = 0; i < 3; i++)
            mag_q[i] <= vec_q[i][63] ? 64'(-vec_q[i]) : 64'(vec_q[i]);
          shcnt_q <= '0;
          state_q <= S_NORM_SHIFT;
        end
        S_NORM_SHIFT: begin
          if (mx == 64'd0) begin
            for (int i = 0; i < 3; i++) vec_q[i] <= '0;
            state_q <= S_NORM_DONE;
          end else if (mx >= 64'h8000_0000) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else if (mx < 64'h4000_0000) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          end else begin
            sum_q <= '0; comp_q <= 2'd0; state_q <= S_NORM_SQ;
          end
        end
        S_NORM_SQ: begin
          sum_q <= sum_q + 64'(mul_p);
          if (comp_q == 2'd2) begin
            sq_rem_q <= sum_q + 64'(mul_p);
            sq_res_q <= '0; sq_bit_q <= 64'd1 << 62;
            state_q <= S_SQRT;
          end else comp_q <= comp_q + 2'd1;
        end
        S_SQRT: begin
          if (sq_bit_q == 64'd0) begin
            comp_q <= 2'd0; state_q <= S_NORM_DIV;
          end else begin
            if (sq_rem_q >= sq_trial) begin
              sq_rem_q <= sq_rem_q - sq_trial;
              sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
            end else sq_res_q <= sq_res_q >> 1;
            sq_bit_q <= sq_bit_q >> 2;
          end
        end
        S_NORM_DIV: state_q <= S_NORM_DIV_W;
        S_NORM_DIV_W: if (!div_busy) begin
          vec_q[comp_q] <= vec_q[comp_q][63] ? -signed'(div_quot) : signed'(div_quot);
          if (comp_q == 2'd2) state_q <= S_NORM_DONE;
          else begin comp_q <= comp_q + 2'd1; state_q <= S_NORM_DIV; end
        end
        S_NORM_DONE: begin
          if (!final_q) begin
            for (int i = 0; i < 3; i++) acc_q[i] <= acc_q[i] + vec_q[i];
            face_q <= face_q + 3'd1;
            state_q <= S_FACE_SEL;
          end else begin
            res_q.normal_x <= sat14(vec_q[0]);
            res_q.normal_y <= sat14(vec_q[1]);
            res_q.normal_z <= sat14(vec_q[2]);
            sum_q <= shade_abs;
            tex_q <= 1'b0;
            state_q <= S_SHADE;
          end
        end
        S_SHADE: begin
          res_q.shade <= sat14(shade_sum[63] ? -shade_mag : shade_mag);
          state_q <= S_TEX_DIV;
        end
        S_TEX_DIV: begin
          if (!tex_q) res_q.pos_y <= (posy_val > 40'hFF_FFFF) ? 24'hFF_FFFF : posy_val[23:0];
          else res_q.pos_z <= half_sat(mul_p);
          state_q <= S_TEX_DIV_W;
        end
        S_TEX_DIV_W: if (!div_busy) begin
          if (!tex_q) begin
            res_q.tex_u <= div_quot[16:0]; tex_q <= 1'b1; state_q <= S_TEX_DIV;
          end else begin
            res_q.tex_v <= div_quot[16:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: if (out_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// File: sv/hvne_divider.sv
// ----------------------------------------------------------------------------
// hvne_divider: radix-2 restoring divider
// Unsigned 64 by 32 bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module hvne_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    trial  = {rem_q[31:0], quot_q[63]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 7'd64;
    end else if (cnt_q != 7'd0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = (cnt_q != 7'd0) || start_i;
  assign quot_o = quot_q;
endmodule

// File: sv/hvne_checker.sv
// ----------------------------------------------------------------------------
// hvne_checker: port-level checks for the heightmap vertex engine
// Watches handshakes and result ranges on the top level.
// ----------------------------------------------------------------------------
module hvne_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hvne_pkg::out_item_t out_data_o
);
  import hvne_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item dropped or changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input item withdrawn before it was taken");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.normal_y >= -16'sd16384 && out_data_o.normal_y <= 16'sd16384)
    else $error("normal out of range");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tex_u <= 17'd65536 && out_data_o.tex_v <= 17'd65536)
    else $error("texture coordinate out of range");
endmodule

bind heightmap_vertex_normal_engine hvne_checker u_hvne_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

// File: tb/heightmap_vertex_normal_engine_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_engine_checker: vertex attribute predictor
// Watches the config, input and output channels, keeps its own copy of the
// grid registers and height samples, predicts each vertex read and compares
// the returned attributes field by field, oldest first.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_engine_checker
  import hvne_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_item_t cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [15:0] height_mirror [MaxRows*MaxColumns];
  logic [8:0]  cols_reg, rows_reg;
  logic [15:0] spacing_reg, scale_reg;
  out_item_t   vertex_q [$];
  int          shown;

  function automatic longint unsigned dim_used(logic [8:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Scale a vector to length 2^q; the zero vector stays zero.
  function automatic void unit_vector(input longint v [3], output longint o [3],
                                      input int q);
    longint unsigned m [3];
    longint unsigned mx, sum, len, r;
    int up, down;
    mx = 0; sum = 0; up = 0; down = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
      return;
    end
    while (mx >= (64'h1 << 31)) begin mx >>= 1; down++; end
    while (mx < (64'h1 << 30)) begin mx <<= 1; up++; end
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> down) << up;
      sum += m[i] * m[i];
    end
    len = floor_root(sum);
    for (int i = 0; i < 3; i++) begin
      r = ((m[i] << q) + len / 2) / len;
      o[i] = v[i] < 0 ? -longint'(r) : longint'(r);
    end
  endfunction

  function automatic longint sample(longint unsigned r, longint unsigned c);
    return longint'(height_mirror[(r * MaxColumns + c) & 16'hFFFF]);
  endfunction

  // Accumulate the unit normal (scale 2^28) of the upper or lower triangle.
  function automatic void add_triangle(input longint unsigned r, input longint unsigned c,
                                       input bit lower, inout longint acc [3]);
    longint k, h0;
    longint f [3];
    longint n [3];
    k = longint'(scale_reg);
    f[1] = longint'(spacing_reg) * 256;
    if (f[1] == 0) return;
    if (!lower) begin
      h0 = sample(r, c);
      f[0] = -(sample(r, c + 1) - h0) * k;
      f[2] = (sample(r + 1, c) - h0) * k;
    end else begin
      h0 = sample(r + 1, c + 1);
      f[0] = -(h0 - sample(r + 1, c)) * k;
      f[2] = (h0 - sample(r, c + 1)) * k;
    end
    unit_vector(f, n, 28);
    for (int i = 0; i < 3; i++) acc[i] += n[i];
  endfunction

  function automatic longint round_half(longint p);
    longint m;
    m = p < 0 ? -p : p;
    m = (m + 1) >>> 1;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint unsigned tex_ratio(longint unsigned i, longint unsigned n);
    longint unsigned d;
    d = n - 1;
    return (i * 131072 + d) / (2 * d);
  endfunction

  function automatic out_item_t vertex_attrs(longint unsigned r, longint unsigned c);
    out_item_t e;
    longint unsigned lr, lc, sm;
    longint px, py, pz, sh;
    longint acc [3];
    longint n [3];
    lr = dim_used(rows_reg, MaxRows) - 1;
    lc = dim_used(cols_reg, MaxColumns) - 1;
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    px = round_half((2 * longint'(c) - longint'(lc)) * longint'(spacing_reg));
    pz = -round_half((2 * longint'(r) - longint'(lr)) * longint'(spacing_reg));
    py = (sample(r, c) * longint'(scale_reg) + 128) >>> 8;
    if (r < lr && c < lc) add_triangle(r, c, 1'b0, acc);
    if (r < lr && c >= 1) begin
      add_triangle(r, c - 1, 1'b0, acc);
      add_triangle(r, c - 1, 1'b1, acc);
    end
    if (r >= 1 && c < lc) begin
      add_triangle(r - 1, c, 1'b0, acc);
      add_triangle(r - 1, c, 1'b1, acc);
    end
    if (r >= 1 && c >= 1) add_triangle(r - 1, c - 1, 1'b1, acc);
    unit_vector(acc, n, 14);
    sh = n[0] + n[1];
    sm = longint'(sh < 0 ? -sh : sh) * longint'(InvSqrt2Q30);
    sm = (sm + (64'h1 << 29)) >> 30;
    sh = sh < 0 ? -longint'(sm) : longint'(sm);
    e.pos_x    = 24'(clip(px, -8388608, 8388607));
    e.pos_y    = 24'(clip(py, 0, 16777215));
    e.pos_z    = 24'(clip(pz, -8388608, 8388607));
    e.tex_u    = 17'(tex_ratio(c, lc + 1));
    e.tex_v    = 17'(tex_ratio(r, lr + 1));
    e.normal_x = 16'(clip(n[0], -16384, 16384));
    e.normal_y = 16'(clip(n[1], -16384, 16384));
    e.normal_z = 16'(clip(n[2], -16384, 16384));
    e.shade    = 16'(clip(sh, -16384, 16384));
    return e;
  endfunction

  task automatic field_check(string f, longint e, longint g);
    if (e != g) begin
      fail_count_o++;
      if (shown < 10) $display("vertex %s mismatch: expected %0d got %0d", f, e, g);
      shown++;
    end
  endtask

  task automatic compare_vertex(out_item_t e, out_item_t g);
    field_check("pos_x", e.pos_x, g.pos_x);
    field_check("pos_y", e.pos_y, g.pos_y);
    field_check("pos_z", e.pos_z, g.pos_z);
    field_check("tex_u", e.tex_u, g.tex_u);
    field_check("tex_v", e.tex_v, g.tex_v);
    field_check("normal_x", e.normal_x, g.normal_x);
    field_check("normal_y", e.normal_y, g.normal_y);
    field_check("normal_z", e.normal_z, g.normal_z);
    field_check("shade", e.shade, g.shade);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (height_mirror[i]) height_mirror[i] = '0;
      cols_reg = 9'd2;
      rows_reg = 9'd2;
      spacing_reg = 16'd256;
      scale_reg = 16'd256;
      vertex_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      shown = 0;
    end else begin
      // Results first: one leaving on the same edge belongs to an older read.
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          fail_count_o++;
          if (shown < 10) $display("unexpected vertex item: got %h", out_data_i);
          shown++;
        end else begin
          compare_vertex(vertex_q.pop_front(), out_data_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.reg_idx)
          3'(RegColumns): cols_reg    = cfg_data_i.data[8:0];
          3'(RegRows):    rows_reg    = cfg_data_i.data[8:0];
          3'(RegSpacing): spacing_reg = cfg_data_i.data[15:0];
          3'(RegScale):   scale_reg   = cfg_data_i.data[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.row < dim_used(rows_reg, MaxRows) &&
            in_data_i.col < dim_used(cols_reg, MaxColumns)) begin
          if (in_data_i.op == OpStore)
            height_mirror[{in_data_i.row, in_data_i.col}] = in_data_i.height;
          else
            vertex_q = {vertex_q, vertex_attrs(in_data_i.row, in_data_i.col)};
        end
      end
      pending_o = vertex_q.size();
    end
  end

endmodule

// File: tb/heightmap_vertex_normal_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_engine_tb: heightmap vertex engine testbench
// Drives grid settings, height stores and vertex reads through random idling
// and back-pressure; the checker predicts and compares every vertex item.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_engine_tb;
  import hvne_pkg::*;

  localparam int ItemTarget   = 1550;
  localparam int QuietFrom    = 1420;
  localparam int LongHold     = 4000;
  localparam int SettleCycles = 1600;
  localparam int CycleLimit   = 12000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_item_t cfg_data = '0;
  int        fail_count, pending;

  int  cycles = 0;
  int  counted = 0;
  bit  quiet = 1'b0;
  int  hold_asks = 0;
  int  cols_used = 2, rows_used = 2;
  bit  written [MaxRows*MaxColumns];

  heightmap_vertex_normal_engine u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  heightmap_vertex_normal_engine_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("heightmap_vertex_normal_engine_tb failed");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request, none at the end.
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        out_ready = 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else if (!quiet && rst_ni && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        out_ready = rst_ni;
      end
    end
  end

  task automatic send_item(logic op, int r, int c, logic [15:0] h);
    in_data = '{op: op, row: 8'(r), col: 8'(c), height: h};
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    in_valid = 1'b0;
    if (op == OpStore && r < rows_used && c < cols_used) written[r*MaxColumns+c] = 1'b1;
    quiet = counted >= QuietFrom;
    if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 13)) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_data = '{reg_idx: idx, data: val};
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Hold until every vertex item is back and the block has gone quiet.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic int clamp_dim(int v, int hi);
    return v < 2 ? 2 : (v > hi ? hi : v);
  endfunction

  task automatic set_grid(int cols, int rows, int sp, int sc);
    drain();
    cfg_write(3'(RegColumns), ($urandom & ~32'h1FF) | 32'(cols));
    cfg_write(3'(RegRows), ($urandom & ~32'h1FF) | 32'(rows));
    cfg_write(3'(RegSpacing), ($urandom & ~32'hFFFF) | 32'(sp));
    cfg_write(3'(RegScale), ($urandom & ~32'hFFFF) | 32'(sc));
    if ($urandom_range(0, 2) == 0) cfg_write(3'($urandom_range(4, 7)), $urandom);
    cols_used = clamp_dim(cols, MaxColumns);
    rows_used = clamp_dim(rows, MaxRows);
  endtask

  function automatic bit readable(int r, int c);
    if (r >= rows_used || c >= cols_used) return 1'b0;
    for (int i = r - 1; i <= r + 1; i++)
      for (int j = c - 1; j <= c + 1; j++)
        if (i >= 0 && j >= 0 && i < rows_used && j < cols_used && !written[i*MaxColumns+j])
          return 1'b0;
    return 1'b1;
  endfunction

  function automatic int patch_origin(int dim, int len);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return dim - len;
      default: return $urandom_range(0, dim - len);
    endcase
  endfunction

  task automatic send_noise();
    int r, c;
    if ($urandom_range(0, 1) == 0 || (rows_used == MaxRows && cols_used == MaxColumns)) begin
      // store anywhere inside the grid
      r = $urandom_range(0, rows_used - 1);
      c = $urandom_range(0, cols_used - 1);
      send_item(OpStore, r, c, 16'($urandom));
      counted++;
    end else begin
      // outside the grid: ignored store or read with no answer
      r = $urandom_range(0, 255);
      c = $urandom_range(0, 255);
      if (rows_used < MaxRows && (cols_used == MaxColumns || $urandom_range(0, 1)))
        r = $urandom_range(rows_used, 255);
      else
        c = $urandom_range(cols_used, 255);
      send_item(logic'($urandom_range(0, 1)), r, c, 16'($urandom));
    end
  endtask

  task automatic run_patch(bit press);
    int h, w, r0, c0, mode, r, c, reads;
    logic [15:0] base, hv;
    h = $urandom_range(2, 6);
    w = $urandom_range(2, 6);
    if (h > rows_used) h = rows_used;
    if (w > cols_used) w = cols_used;
    r0 = patch_origin(rows_used, h);
    c0 = patch_origin(cols_used, w);
    mode = $urandom_range(0, 3);
    base = 16'($urandom);
    for (int i = r0; i < r0 + h; i++)
      for (int j = c0; j < c0 + w; j++) begin
        case (mode)
          0: hv = 16'($urandom);
          1: hv = base + 16'($urandom_range(0, 512)) - 16'd256;
          2: hv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: hv = base;
        endcase
        send_item(OpStore, i, j, hv);
        counted++;
        if ($urandom_range(0, 9) == 0) send_noise();
      end
    if (press) hold_asks++;
    reads = $urandom_range(4, 16);
    for (int k = 0; k < reads; k++) begin
      r = $urandom_range(r0, r0 + h - 1);
      c = $urandom_range(c0, c0 + w - 1);
      if (readable(r, c)) begin
        send_item(OpRead, r, c, 16'($urandom));
        counted++;
      end
      if ($urandom_range(0, 7) == 0) send_noise();
    end
  endtask

  initial begin
    int phase, cols, rows, sp, sc;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset grid, extreme heights, every corner, out-of-grid items.
    send_item(OpStore, 0, 0, 16'h0000);
    send_item(OpStore, 0, 1, 16'hFFFF);
    send_item(OpStore, 1, 0, 16'h8000);
    send_item(OpStore, 1, 1, 16'h0001);
    for (int i = 0; i < 4; i++) send_item(OpRead, i / 2, i % 2, 16'hFFFF);
    send_item(OpStore, 255, 255, 16'hFFFF);
    send_item(OpRead, 2, 0, 16'h0000);
    send_item(OpRead, 0, 255, 16'h0000);
    send_item(OpStore, 0, 0, 16'hFFFF);
    send_item(OpStore, 1, 1, 16'hFFFF);
    send_item(OpRead, 0, 0, 16'h0000);
    send_item(OpRead, 1, 1, 16'h0000);
    counted = 15;

    phase = 0;
    while (counted < ItemTarget) begin
      case (phase)
        0: begin cols = 0;   rows = 1;   sp = 0;     sc = 65535; end
        1: begin cols = 256; rows = 256; sp = 65535; sc = 65535; end
        2: begin cols = 511; rows = 300; sp = 1;     sc = 0;     end
        3: begin cols = 17;  rows = 5;   sp = 300;   sc = 40000; end
        4: begin cols = 3;   rows = 256; sp = 65535; sc = 1;     end
        5: begin cols = 256; rows = 2;   sp = 0;     sc = 256;   end
        default: begin
          cols = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511) : $urandom_range(2, 24);
          rows = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511) : $urandom_range(2, 24);
          case ($urandom_range(0, 3))
            0: sp = $urandom_range(0, 65535);
            1: sp = $urandom_range(1, 1024);
            2: sp = $urandom_range(0, 1) ? 0 : 65535;
            default: sp = 256;
          endcase
          case ($urandom_range(0, 3))
            0: sc = $urandom_range(0, 65535);
            1: sc = $urandom_range(0, 1024);
            2: sc = $urandom_range(0, 1) ? 0 : 65535;
            default: sc = 256;
          endcase
        end
      endcase
      set_grid(cols, rows, sp, sc);
      repeat ($urandom_range(1, 3)) run_patch(phase == 3);
      phase++;
    end

    in_valid = 1'b0;
    drain();
    if (fail_count == 0 && pending == 0)
      $display("heightmap_vertex_normal_engine_tb passed");
    else
      $display("heightmap_vertex_normal_engine_tb failed");
    $finish;
  end

endmodule

// File: files.f
sv/hvne_pkg.sv
sv/hvne_divider.sv
sv/heightmap_vertex_normal_engine.sv
sv/hvne_checker.sv
tb/heightmap_vertex_normal_engine_checker.sv
tb/heightmap_vertex_normal_engine_tb.sv
